[design/sts_pkg.sv]
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and codes for the script token scanner: token kinds, scan
// modes, pending operators, character codes and the per-byte result bundle.
// ----------------------------------------------------------------------------
package sts_pkg;

   localparam int LINE_BITS_DEFAULT   = 16;
   localparam int LENGTH_BITS_DEFAULT = 16;
   localparam int KIND_BITS           = 5;
   localparam int CHAR_BITS           = 8;
   localparam int MAX_TOKENS          = 3;
   localparam int COUNT_BITS          = 2;

   typedef logic [KIND_BITS-1:0] kind_type;
   typedef logic [CHAR_BITS-1:0] char_type;

   localparam kind_type KIND_LPAREN       = 5'd0;
   localparam kind_type KIND_RPAREN       = 5'd1;
   localparam kind_type KIND_LBRACE       = 5'd2;
   localparam kind_type KIND_RBRACE       = 5'd3;
   localparam kind_type KIND_PLUS         = 5'd4;
   localparam kind_type KIND_MINUS        = 5'd5;
   localparam kind_type KIND_STAR         = 5'd6;
   localparam kind_type KIND_SEMICOLON    = 5'd7;
   localparam kind_type KIND_DOT          = 5'd8;
   localparam kind_type KIND_COMMA        = 5'd9;
   localparam kind_type KIND_BANG         = 5'd10;
   localparam kind_type KIND_BANG_EQUAL   = 5'd11;
   localparam kind_type KIND_SLASH        = 5'd18;
   localparam kind_type KIND_NUMBER       = 5'd19;
   localparam kind_type KIND_STRING       = 5'd20;
   localparam kind_type KIND_EOF          = 5'd21;
   localparam kind_type KIND_UNEXPECTED   = 5'd22;
   localparam kind_type KIND_UNTERMINATED = 5'd23;

   localparam char_type CHAR_LPAREN    = 8'h28;
   localparam char_type CHAR_RPAREN    = 8'h29;
   localparam char_type CHAR_LBRACE    = 8'h7B;
   localparam char_type CHAR_RBRACE    = 8'h7D;
   localparam char_type CHAR_PLUS      = 8'h2B;
   localparam char_type CHAR_MINUS     = 8'h2D;
   localparam char_type CHAR_STAR      = 8'h2A;
   localparam char_type CHAR_SEMICOLON = 8'h3B;
   localparam char_type CHAR_DOT       = 8'h2E;
   localparam char_type CHAR_COMMA     = 8'h2C;
   localparam char_type CHAR_BANG      = 8'h21;
   localparam char_type CHAR_EQUALS    = 8'h3D;
   localparam char_type CHAR_GREATER   = 8'h3E;
   localparam char_type CHAR_LESS      = 8'h3C;
   localparam char_type CHAR_SLASH     = 8'h2F;
   localparam char_type CHAR_QUOTE     = 8'h22;
   localparam char_type CHAR_SPACE     = 8'h20;
   localparam char_type CHAR_CR        = 8'h0D;
   localparam char_type CHAR_TAB       = 8'h09;
   localparam char_type CHAR_NEWLINE   = 8'h0A;
   localparam char_type CHAR_UNDERSCORE = 8'h5F;

   typedef enum logic [7:0] {
      MODE_IDLE    = 8'b0000_0001,
      MODE_OP      = 8'b0000_0010,
      MODE_SLASH   = 8'b0000_0100,
      MODE_COMMENT = 8'b0000_1000,
      MODE_INT     = 8'b0001_0000,
      MODE_DOT     = 8'b0010_0000,
      MODE_FRAC    = 8'b0100_0000,
      MODE_STRING  = 8'b1000_0000
   } mode_type;

   typedef enum logic [1:0] {
      OP_BANG    = 2'd0,
      OP_EQUAL   = 2'd1,
      OP_GREATER = 2'd2,
      OP_LESS    = 2'd3
   } op_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]                count;
      logic [MAX_TOKENS-1:0][KIND_BITS-1:0] kind;
   } bundle_type;

endpackage

[design/sts_scan_core.sv]
// ----------------------------------------------------------------------------
// sts_scan_core
// Scanner state and per-byte decode: works out the tokens one source byte
// (or the end marker) gives and the state it leaves behind.
// ----------------------------------------------------------------------------
module sts_scan_core
   import sts_pkg::*;
#(
   parameter int LINE_BITS   = LINE_BITS_DEFAULT,
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  char_type               in_ch,
   input  logic                   in_eos,
   output bundle_type             bundle,
   output logic [LINE_BITS-1:0]   tok_line,
   output logic [LENGTH_BITS-1:0] tok_length
);

   mode_type               mode_ff, mode_in;
   op_type                 pend_ff, pend_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [LENGTH_BITS-1:0] run_ff, run_in;

   logic [LENGTH_BITS-1:0] run_inc, run_inc2;
   logic [LINE_BITS-1:0]   line_inc_val;
   logic                   is_digit, is_letter;

   logic     f_emit, f_nl, f_run_set, f_run_one;
   kind_type f_kind;
   mode_type f_mode;
   op_type   f_op;

   logic [COUNT_BITS-1:0] pre_n;
   kind_type              pre_k0, pre_k1, tail_kind, op_kind, op_eq_kind;
   logic                  use_fresh, tail_emit, line_inc, clear;

   assign is_digit  = in_ch inside {[8'h30:8'h39]};
   assign is_letter = (in_ch inside {[8'h61:8'h7A]}) || (in_ch inside {[8'h41:8'h5A]})
                      || (in_ch == CHAR_UNDERSCORE);

   assign run_inc      = (run_ff == '1) ? run_ff : run_ff + LENGTH_BITS'(1);
   assign run_inc2     = (run_inc == '1) ? run_inc : run_inc + LENGTH_BITS'(1);
   assign line_inc_val = (line_ff == '1) ? line_ff : line_ff + LINE_BITS'(1);

   assign op_kind    = KIND_BANG + kind_type'({pend_ff, 1'b0});
   assign op_eq_kind = KIND_BANG_EQUAL + kind_type'({pend_ff, 1'b0});

   always_comb begin
      f_emit    = 1'b0;
      f_kind    = KIND_UNEXPECTED;
      f_mode    = MODE_IDLE;
      f_op      = pend_ff;
      f_nl      = 1'b0;
      f_run_set = 1'b0;
      f_run_one = 1'b0;
      if (is_digit) begin
         f_mode    = MODE_INT;
         f_run_set = 1'b1;
         f_run_one = 1'b1;
      end else if (!is_letter) begin
         case (in_ch)
            CHAR_LPAREN:    begin f_emit = 1'b1; f_kind = KIND_LPAREN;    end
            CHAR_RPAREN:    begin f_emit = 1'b1; f_kind = KIND_RPAREN;    end
            CHAR_LBRACE:    begin f_emit = 1'b1; f_kind = KIND_LBRACE;    end
            CHAR_RBRACE:    begin f_emit = 1'b1; f_kind = KIND_RBRACE;    end
            CHAR_PLUS:      begin f_emit = 1'b1; f_kind = KIND_PLUS;      end
            CHAR_MINUS:     begin f_emit = 1'b1; f_kind = KIND_MINUS;     end
            CHAR_STAR:      begin f_emit = 1'b1; f_kind = KIND_STAR;      end
            CHAR_SEMICOLON: begin f_emit = 1'b1; f_kind = KIND_SEMICOLON; end
            CHAR_DOT:       begin f_emit = 1'b1; f_kind = KIND_DOT;       end
            CHAR_COMMA:     begin f_emit = 1'b1; f_kind = KIND_COMMA;     end
            CHAR_BANG:      begin f_mode = MODE_OP; f_op = OP_BANG;       end
            CHAR_EQUALS:    begin f_mode = MODE_OP; f_op = OP_EQUAL;      end
            CHAR_GREATER:   begin f_mode = MODE_OP; f_op = OP_GREATER;    end
            CHAR_LESS:      begin f_mode = MODE_OP; f_op = OP_LESS;       end
            CHAR_SLASH:     f_mode = MODE_SLASH;
            CHAR_QUOTE:     begin f_mode = MODE_STRING; f_run_set = 1'b1; end
            CHAR_SPACE, CHAR_CR, CHAR_TAB: ;
            CHAR_NEWLINE:   f_nl = 1'b1;
            default:        f_emit = 1'b1;
         endcase
      end
   end

   always_comb begin
      pre_n     = '0;
      pre_k0    = KIND_NUMBER;
      pre_k1    = KIND_DOT;
      use_fresh = 1'b0;
      mode_in   = mode_ff;
      pend_in   = pend_ff;
      run_in    = run_ff;
      line_inc  = 1'b0;
      clear     = 1'b0;
      if (in_eos) begin
         clear = 1'b1;
         case (mode_ff)
            MODE_OP:    begin pre_n = 2'd1; pre_k0 = op_kind;           end
            MODE_SLASH: begin pre_n = 2'd1; pre_k0 = KIND_SLASH;        end
            MODE_INT, MODE_FRAC: pre_n = 2'd1;
            MODE_DOT:   pre_n = 2'd2;
            MODE_STRING: begin pre_n = 2'd1; pre_k0 = KIND_UNTERMINATED; end
            default: ;
         endcase
      end else begin
         case (mode_ff)
            MODE_OP: begin
               mode_in = MODE_IDLE;
               pre_n   = 2'd1;
               if (in_ch == CHAR_EQUALS) begin
                  pre_k0 = op_eq_kind;
               end else begin
                  pre_k0    = op_kind;
                  use_fresh = 1'b1;
               end
            end
            MODE_SLASH: begin
               if (in_ch == CHAR_SLASH) begin
                  mode_in = MODE_COMMENT;
               end else begin
                  pre_n     = 2'd1;
                  pre_k0    = KIND_SLASH;
                  use_fresh = 1'b1;
               end
            end
            MODE_COMMENT: begin
               if (in_ch == CHAR_NEWLINE) begin
                  line_inc = 1'b1;
                  mode_in  = MODE_IDLE;
               end
            end
            MODE_INT: begin
               if (is_digit) begin
                  run_in = run_inc;
               end else if (in_ch == CHAR_DOT) begin
                  mode_in = MODE_DOT;
               end else begin
                  pre_n     = 2'd1;
                  use_fresh = 1'b1;
               end
            end
            MODE_DOT: begin
               if (is_digit) begin
                  run_in  = run_inc2;
                  mode_in = MODE_FRAC;
               end else begin
                  pre_n     = 2'd2;
                  use_fresh = 1'b1;
               end
            end
            MODE_FRAC: begin
               if (is_digit) begin
                  run_in = run_inc;
               end else begin
                  pre_n     = 2'd1;
                  use_fresh = 1'b1;
               end
            end
            MODE_STRING: begin
               if (in_ch == CHAR_QUOTE) begin
                  pre_n   = 2'd1;
                  pre_k0  = KIND_STRING;
                  mode_in = MODE_IDLE;
               end else begin
                  line_inc = (in_ch == CHAR_NEWLINE);
                  run_in   = run_inc;
               end
            end
            default: use_fresh = 1'b1;
         endcase
         if (use_fresh) begin
            mode_in  = f_mode;
            pend_in  = f_op;
            line_inc = f_nl;
            if (f_run_set) begin
               run_in = f_run_one ? LENGTH_BITS'(1) : '0;
            end
         end
      end
   end

   assign tail_emit = in_eos || (use_fresh && f_emit);
   assign tail_kind = in_eos ? KIND_EOF : f_kind;

   always_comb begin
      bundle.count   = pre_n + COUNT_BITS'(tail_emit);
      bundle.kind[0] = (pre_n != 2'd0) ? pre_k0 : tail_kind;
      bundle.kind[1] = (pre_n == 2'd2) ? pre_k1 : tail_kind;
      bundle.kind[2] = tail_kind;
   end

   assign tok_line   = line_ff;
   assign tok_length = run_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         pend_ff <= OP_BANG;
         line_ff <= LINE_BITS'(1);
         run_ff  <= '0;
      end else if (advance) begin
         if (clear) begin
            mode_ff <= MODE_IDLE;
            pend_ff <= OP_BANG;
            line_ff <= LINE_BITS'(1);
            run_ff  <= '0;
         end else begin
            mode_ff <= mode_in;
            pend_ff <= pend_in;
            line_ff <= line_inc ? line_inc_val : line_ff;
            run_ff  <= run_in;
         end
      end
   end

endmodule

[design/sts_result_buffer.sv]
// ----------------------------------------------------------------------------
// sts_result_buffer
// Result register: holds the tokens of one source byte and hands them out
// one transfer at a time.
// ----------------------------------------------------------------------------
module sts_result_buffer
   import sts_pkg::*;
#(
   parameter int LINE_BITS   = LINE_BITS_DEFAULT,
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  bundle_type             bundle,
   input  logic [LINE_BITS-1:0]   tok_line,
   input  logic [LENGTH_BITS-1:0] tok_length,
   output logic                   free,
   output logic                   out_valid,
   input  logic                   out_ready,
   output kind_type               out_kind,
   output logic [LINE_BITS-1:0]   out_line,
   output logic [LENGTH_BITS-1:0] out_length,
   output logic                   out_last
);

   logic                   valid_ff;
   logic [COUNT_BITS-1:0]  idx_ff;
   bundle_type             bundle_ff;
   logic [LINE_BITS-1:0]   line_ff;
   logic [LENGTH_BITS-1:0] length_ff;
   logic                   transfer;

   assign out_valid  = valid_ff;
   assign out_kind   = bundle_ff.kind[idx_ff];
   assign out_last   = (idx_ff == bundle_ff.count - COUNT_BITS'(1));
   assign out_line   = line_ff;
   assign out_length = (out_kind == KIND_NUMBER || out_kind == KIND_STRING) ? length_ff : '0;
   assign transfer   = valid_ff && out_ready;
   assign free       = !valid_ff || (transfer && out_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (transfer) begin
         valid_ff <= !out_last;
         idx_ff   <= idx_ff + COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bundle_ff <= bundle;
         line_ff   <= tok_line;
         length_ff <= tok_length;
      end
   end

endmodule

[design/script_token_scanner.sv]
// ----------------------------------------------------------------------------
// script_token_scanner
// Streaming lexical scanner: source bytes in, tokens with kind, line number
// and length out.
// ----------------------------------------------------------------------------
// One source byte is taken per cycle while the result side keeps up. A byte
// lands in the input register, is decoded against the scanner state in a
// single pass and its tokens (none to three) go into the result register,
// which is emptied one token a cycle while rsp_tready is high. A byte that
// gives no token or one token passes at one cycle per byte; a byte that gives
// more holds the result register until its last token is taken, and the next
// token-giving byte waits until then. Token line numbers and lengths saturate;
// after EOF the scanner starts over at line 1.
module script_token_scanner
   import sts_pkg::*;
#(
   parameter int   LINE_BITS   = LINE_BITS_DEFAULT,
   parameter int   LENGTH_BITS = LENGTH_BITS_DEFAULT,
   localparam int  RSP_BITS    = ((KIND_BITS + LINE_BITS + LENGTH_BITS + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // ch
   input  logic                req_tlast,   // end_of_source
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_BITS-1:0] rsp_tdata,   // kind, line_no, token_length
   output logic                rsp_tlast    // last_of_run
);

   logic     in_valid_ff;
   char_type in_ch_ff;
   logic     in_eos_ff;
   logic     advance, load, buf_free;

   bundle_type             bundle;
   logic [LINE_BITS-1:0]   tok_line, out_line;
   logic [LENGTH_BITS-1:0] tok_length, out_length;
   kind_type               out_kind;

   assign advance    = in_valid_ff && ((bundle.count == '0) || buf_free);
   assign load       = advance && (bundle.count != '0);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ch_ff  <= req_tdata;
         in_eos_ff <= req_tlast;
      end
   end

   sts_scan_core #(
      .LINE_BITS   (LINE_BITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_scan_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_ch      (in_ch_ff),
      .in_eos     (in_eos_ff),
      .bundle     (bundle),
      .tok_line   (tok_line),
      .tok_length (tok_length)
   );

   sts_result_buffer #(
      .LINE_BITS   (LINE_BITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_result_buffer (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .bundle     (bundle),
      .tok_line   (tok_line),
      .tok_length (tok_length),
      .free       (buf_free),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_kind   (out_kind),
      .out_line   (out_line),
      .out_length (out_length),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = RSP_BITS'({out_length, out_line, out_kind});

endmodule

[design/sts_checker.sv]
// ----------------------------------------------------------------------------
// sts_checker
// Port-level checks on the token stream of the script token scanner.
// ----------------------------------------------------------------------------
module sts_checker
   import sts_pkg::*;
#(
   parameter int  LINE_BITS   = LINE_BITS_DEFAULT,
   parameter int  LENGTH_BITS = LENGTH_BITS_DEFAULT,
   localparam int RSP_BITS    = ((KIND_BITS + LINE_BITS + LENGTH_BITS + 7) / 8) * 8
) (
   input logic                clock,
   input logic                reset,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RSP_BITS-1:0] rsp_tdata,
   input logic                rsp_tlast
);

   kind_type               kind;
   logic [LINE_BITS-1:0]   line_no;
   logic [LENGTH_BITS-1:0] length;

   assign kind    = rsp_tdata[KIND_BITS-1:0];
   assign line_no = rsp_tdata[KIND_BITS +: LINE_BITS];
   assign length  = rsp_tdata[KIND_BITS + LINE_BITS +: LENGTH_BITS];

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled transfer changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> line_no != '0)
      else $error("line number zero");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && kind != KIND_NUMBER && kind != KIND_STRING |-> length == '0)
      else $error("length on a token without one");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && kind == KIND_NUMBER |-> length != '0)
      else $error("empty number");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && kind == KIND_EOF |-> rsp_tlast)
      else $error("EOF not last of its run");

endmodule

bind script_token_scanner sts_checker #(
   .LINE_BITS   (LINE_BITS),
   .LENGTH_BITS (LENGTH_BITS)
) u_sts_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
